// File: src/jsu_pkg.sv
package jsu_pkg;

    localparam int MaxResults = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX_FIRST,
        MODE_WANT_BSLASH,
        MODE_WANT_U,
        MODE_HEX_SECOND
    } mode_t;

    localparam logic [3:0] ST_BYTE      = 4'd0;
    localparam logic [3:0] ST_DONE      = 4'd1;
    localparam logic [3:0] ST_UNTERM    = 4'd2;
    localparam logic [3:0] ST_OPEN_ESC  = 4'd3;
    localparam logic [3:0] ST_SHORT_HEX = 4'd4;
    localparam logic [3:0] ST_BAD_HEX   = 4'd5;
    localparam logic [3:0] ST_SURROGATE = 4'd6;
    localparam logic [3:0] ST_BAD_ESC   = 4'd7;
    localparam logic [3:0] ST_NO_QUOTE  = 4'd8;

    // results caused by one input word; status applies to every entry
    typedef struct packed {
        logic [2:0]                 cnt;
        logic [3:0]                 status;
        logic [MaxResults-1:0][7:0] data;
    } bundle_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex;
        logic [1:0]  digits;
        logic [9:0]  high;
    } scan_t;

    localparam scan_t SCAN_RESET = '{mode: MODE_IDLE, hex: 16'h0, digits: 2'd0, high: 10'h0};

endpackage

// File: src/jsu_scan.sv
module jsu_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          text_byte,
    input  logic                text_end,
    output jsu_pkg::bundle_t    bundle
);

    jsu_pkg::scan_t scan_reg;
    jsu_pkg::scan_t scan_next;

    logic [4:0]  digit;
    logic [15:0] hex_word;
    logic [20:0] pair_cp;

    // 0..15 for a hex digit, 16 otherwise
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
        return r;
    endfunction

    function automatic jsu_pkg::bundle_t utf8(input logic [20:0] cp);
        jsu_pkg::bundle_t b;
        b = '0;
        b.status = jsu_pkg::ST_BYTE;
        if (cp < 21'h80) begin
            b.cnt     = 3'd1;
            b.data[0] = cp[7:0];
        end
        else if (cp < 21'h800) begin
            b.cnt     = 3'd2;
            b.data[0] = {3'b110, cp[10:6]};
            b.data[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            b.cnt     = 3'd3;
            b.data[0] = {4'b1110, cp[15:12]};
            b.data[1] = {2'b10, cp[11:6]};
            b.data[2] = {2'b10, cp[5:0]};
        end
        else begin
            b.cnt     = 3'd4;
            b.data[0] = {5'b11110, cp[20:18]};
            b.data[1] = {2'b10, cp[17:12]};
            b.data[2] = {2'b10, cp[11:6]};
            b.data[3] = {2'b10, cp[5:0]};
        end
        return b;
    endfunction

    function automatic jsu_pkg::bundle_t fin(input logic [3:0] st);
        jsu_pkg::bundle_t b;
        b        = '0;
        b.cnt    = 3'd1;
        b.status = st;
        return b;
    endfunction

    assign digit    = hex_of(text_byte);
    assign hex_word = {scan_reg.hex[11:0], digit[3:0]};
    assign pair_cp  = 21'({scan_reg.high, hex_word[9:0]}) + 21'h1_0000;

    always_comb
    begin
        scan_next = scan_reg;
        bundle    = '0;
        unique case (scan_reg.mode)
            jsu_pkg::MODE_STR:
            begin
                if (text_end) begin
                    scan_next = jsu_pkg::SCAN_RESET;
                    bundle    = fin(jsu_pkg::ST_UNTERM);
                end
                else if (text_byte == 8'h22) begin
                    scan_next = jsu_pkg::SCAN_RESET;
                    bundle    = fin(jsu_pkg::ST_DONE);
                end
                else if (text_byte == 8'h5C) begin
                    scan_next.mode = jsu_pkg::MODE_ESC;
                end
                else begin
                    bundle.cnt     = 3'd1;
                    bundle.data[0] = text_byte;
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                if (text_end) begin
                    scan_next = jsu_pkg::SCAN_RESET;
                    bundle    = fin(jsu_pkg::ST_OPEN_ESC);
                end
                else begin
                    scan_next.mode = jsu_pkg::MODE_STR;
                    bundle.cnt     = 3'd1;
                    unique case (text_byte)
                        8'h22, 8'h5C, 8'h2F: bundle.data[0] = text_byte;
                        8'h62: bundle.data[0] = 8'h08;
                        8'h66: bundle.data[0] = 8'h0C;
                        8'h6E: bundle.data[0] = 8'h0A;
                        8'h72: bundle.data[0] = 8'h0D;
                        8'h74: bundle.data[0] = 8'h09;
                        8'h75:
                        begin
                            bundle.cnt       = 3'd0;
                            scan_next.mode   = jsu_pkg::MODE_HEX_FIRST;
                            scan_next.hex    = 16'h0;
                            scan_next.digits = 2'd0;
                        end
                        default:
                        begin
                            scan_next = jsu_pkg::SCAN_RESET;
                            bundle    = fin(jsu_pkg::ST_BAD_ESC);
                        end
                    endcase
                end
            end
            jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_SECOND:
            begin
                if (text_end) begin
                    scan_next = jsu_pkg::SCAN_RESET;
                    bundle    = fin(jsu_pkg::ST_SHORT_HEX);
                end
                else if (digit[4]) begin
                    scan_next = jsu_pkg::SCAN_RESET;
                    bundle    = fin(jsu_pkg::ST_BAD_HEX);
                end
                else if (scan_reg.digits != 2'd3) begin
                    scan_next.hex    = hex_word;
                    scan_next.digits = scan_reg.digits + 2'd1;
                end
                else begin
                    scan_next.hex    = 16'h0;
                    scan_next.digits = 2'd0;
                    if (scan_reg.mode == jsu_pkg::MODE_HEX_FIRST) begin
                        if (hex_word[15:10] == 6'b110110) begin
                            scan_next.high = hex_word[9:0];
                            scan_next.mode = jsu_pkg::MODE_WANT_BSLASH;
                        end
                        else begin
                            scan_next.mode = jsu_pkg::MODE_STR;
                            bundle         = utf8({5'd0, hex_word});
                        end
                    end
                    else if (hex_word[15:10] != 6'b110111) begin
                        scan_next = jsu_pkg::SCAN_RESET;
                        bundle    = fin(jsu_pkg::ST_SURROGATE);
                    end
                    else begin
                        scan_next.mode = jsu_pkg::MODE_STR;
                        scan_next.high = 10'h0;
                        bundle         = utf8(pair_cp);
                    end
                end
            end
            jsu_pkg::MODE_WANT_BSLASH:
            begin
                if (text_end || text_byte != 8'h5C) begin
                    scan_next = jsu_pkg::SCAN_RESET;
                    bundle    = fin(jsu_pkg::ST_SURROGATE);
                end
                else begin
                    scan_next.mode = jsu_pkg::MODE_WANT_U;
                end
            end
            jsu_pkg::MODE_WANT_U:
            begin
                if (text_end || text_byte != 8'h75) begin
                    scan_next = jsu_pkg::SCAN_RESET;
                    bundle    = fin(jsu_pkg::ST_SURROGATE);
                end
                else begin
                    scan_next.mode   = jsu_pkg::MODE_HEX_SECOND;
                    scan_next.hex    = 16'h0;
                    scan_next.digits = 2'd0;
                end
            end
            default:
            begin
                scan_next.mode = jsu_pkg::MODE_IDLE;
                if (!text_end && text_byte != 8'h20 && text_byte != 8'h09
                    && text_byte != 8'h0D && text_byte != 8'h0A) begin
                    if (text_byte == 8'h22) begin
                        scan_next.mode = jsu_pkg::MODE_STR;
                    end
                    else begin
                        scan_next = jsu_pkg::SCAN_RESET;
                        bundle    = fin(jsu_pkg::ST_NO_QUOTE);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scan_reg <= jsu_pkg::SCAN_RESET;
        end
        else if (accept) begin
            scan_reg <= scan_next;
        end
    end

endmodule

// File: src/jsu_emit.sv
module jsu_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jsu_pkg::bundle_t    bundle,
    output logic                busy_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic [3:0]          status,
    output logic                run_last
);

    logic [2:0]                          cnt_reg;
    logic [1:0]                          idx_reg;
    logic [3:0]                          status_reg;
    logic [jsu_pkg::MaxResults-1:0][7:0] data_reg;

    logic out_accept;
    logic last;

    assign out_valid  = cnt_reg != 3'd0;
    assign last       = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign out_accept = out_valid && !out_stall;
    assign busy_stall = out_valid && !(out_accept && last);

    assign out_byte = data_reg[idx_reg];
    assign status   = status_reg;
    assign run_last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else if (load) begin
            cnt_reg <= bundle.cnt;
            idx_reg <= 2'd0;
        end
        else if (out_accept) begin
            if (last) begin
                cnt_reg <= 3'd0;
                idx_reg <= 2'd0;
            end
            else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            status_reg <= bundle.status;
            data_reg   <= bundle.data;
        end
    end

endmodule

// File: src/json_string_unescape_utf8_top.sv
// Results of a word appear in the cycle after it is taken.
// Throughput: one input word per cycle while out_stall is low and each word
// makes at most one output word; a word making N UTF-8 bytes holds the input
// until its last byte leaves the single output buffer, one per unstalled cycle.
// Reset (rst_n low, asynchronous): scanner idle, hex state cleared, buffer empty.
module json_string_unescape_utf8_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [3:0] status,
    output logic       run_last
);

    logic             in_accept;
    jsu_pkg::bundle_t bundle;

    assign in_accept = in_valid && !in_stall;

    jsu_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .text_byte (text_byte),
        .text_end  (text_end),
        .bundle    (bundle)
    );

    jsu_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept),
        .bundle     (bundle),
        .busy_stall (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .status     (status),
        .run_last   (run_last)
    );

    a_stall_only_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != jsu_pkg::ST_BYTE) |-> (run_last && out_byte == 8'h00))
        else $error("status word not last or carries data");

    a_multi_byte_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> in_stall)
        else $error("input taken while a multi-byte result is still draining");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [4:0] NOT_HEX   = 5'h10;
    localparam int RandomWords = 200;
    localparam int TimeoutNs   = 4_000_000;

    typedef struct {
        logic [7:0] b;
        logic       e;
        int         gap;
        logic       drain;
    } text_word_t;

    typedef struct {
        logic [7:0] b;
        logic [3:0] st;
        logic       last;
    } utf8_word_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] text_byte = 8'h00;
    logic       text_end  = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       run_last;

    json_string_unescape_utf8_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .text_end  (text_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .run_last  (run_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // scanner copy
    jsu_pkg::mode_t sc_mode   = jsu_pkg::MODE_IDLE;
    logic [15:0]    sc_hex    = 16'h0;
    logic [1:0]     sc_digits = 2'd0;
    logic [9:0]     sc_high   = 10'h0;

    utf8_word_t word_res[$];
    utf8_word_t exp_q[$];
    text_word_t pend_q[$];

    int  n_total  = 0;
    int  n_taken  = 0;
    int  n_errors = 0;
    bit  gen_calm = 1'b0;
    bit  gen_drain = 1'b0;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
        return NOT_HEX;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic emit(input logic [7:0] b, input logic [3:0] st);
        utf8_word_t r;
        r.b = b;
        r.st = st;
        r.last = 1'b0;
        word_res.insert(word_res.size(), r);
    endtask

    task automatic close_run(input logic [3:0] st);
        sc_mode = jsu_pkg::MODE_IDLE;
        sc_hex = 16'h0;
        sc_digits = 2'd0;
        sc_high = 10'h0;
        emit(8'h00, st);
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(cp[7:0], jsu_pkg::ST_BYTE);
        end
        else if (cp < 21'h800) begin
            emit({3'b110, cp[10:6]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
        end
        else if (cp < 21'h10000) begin
            emit({4'b1110, cp[15:12]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
        end
        else begin
            emit({5'b11110, cp[20:18]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[17:12]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
        end
    endtask

    task automatic decode_word(input logic [7:0] c, input logic e);
        logic [4:0] d;
        utf8_word_t r;
        word_res.delete();
        case (sc_mode)
            jsu_pkg::MODE_STR:
            begin
                if (e) close_run(jsu_pkg::ST_UNTERM);
                else if (c == CH_QUOTE) close_run(jsu_pkg::ST_DONE);
                else if (c == CH_BSLASH) sc_mode = jsu_pkg::MODE_ESC;
                else emit(c, jsu_pkg::ST_BYTE);
            end
            jsu_pkg::MODE_ESC:
            begin
                if (e) begin
                    close_run(jsu_pkg::ST_OPEN_ESC);
                end
                else begin
                    sc_mode = jsu_pkg::MODE_STR;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: emit(c, jsu_pkg::ST_BYTE);
                        CH_B: emit(CH_BS, jsu_pkg::ST_BYTE);
                        CH_F: emit(CH_FF, jsu_pkg::ST_BYTE);
                        CH_N: emit(CH_LF, jsu_pkg::ST_BYTE);
                        CH_R: emit(CH_CR, jsu_pkg::ST_BYTE);
                        CH_T: emit(CH_TAB, jsu_pkg::ST_BYTE);
                        CH_U:
                        begin
                            sc_mode = jsu_pkg::MODE_HEX_FIRST;
                            sc_hex = 16'h0;
                            sc_digits = 2'd0;
                        end
                        default: close_run(jsu_pkg::ST_BAD_ESC);
                    endcase
                end
            end
            jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_SECOND:
            begin
                d = hex_val(c);
                if (e) begin
                    close_run(jsu_pkg::ST_SHORT_HEX);
                end
                else if (d == NOT_HEX) begin
                    close_run(jsu_pkg::ST_BAD_HEX);
                end
                else begin
                    sc_hex = {sc_hex[11:0], d[3:0]};
                    if (sc_digits != 2'd3) begin
                        sc_digits = sc_digits + 2'd1;
                    end
                    else begin
                        sc_digits = 2'd0;
                        if (sc_mode == jsu_pkg::MODE_HEX_FIRST) begin
                            if (sc_hex >= 16'hD800 && sc_hex < 16'hDC00) begin
                                sc_high = sc_hex[9:0];
                                sc_mode = jsu_pkg::MODE_WANT_BSLASH;
                            end
                            else begin
                                sc_mode = jsu_pkg::MODE_STR;
                                emit_utf8({5'd0, sc_hex});
                            end
                        end
                        else if (sc_hex < 16'hDC00 || sc_hex >= 16'hE000) begin
                            close_run(jsu_pkg::ST_SURROGATE);
                        end
                        else begin
                            sc_mode = jsu_pkg::MODE_STR;
                            emit_utf8(21'h10000 + {1'b0, sc_high, 10'd0}
                                      + {11'd0, sc_hex[9:0]});
                            sc_high = 10'h0;
                        end
                        sc_hex = 16'h0;
                    end
                end
            end
            jsu_pkg::MODE_WANT_BSLASH:
            begin
                if (e || c != CH_BSLASH) close_run(jsu_pkg::ST_SURROGATE);
                else sc_mode = jsu_pkg::MODE_WANT_U;
            end
            jsu_pkg::MODE_WANT_U:
            begin
                if (e || c != CH_U) begin
                    close_run(jsu_pkg::ST_SURROGATE);
                end
                else begin
                    sc_mode = jsu_pkg::MODE_HEX_SECOND;
                    sc_hex = 16'h0;
                    sc_digits = 2'd0;
                end
            end
            default:
            begin
                sc_mode = jsu_pkg::MODE_IDLE;
                if (!e && !(c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
                    if (c == CH_QUOTE) sc_mode = jsu_pkg::MODE_STR;
                    else close_run(jsu_pkg::ST_NO_QUOTE);
                end
            end
        endcase
        for (int i = 0; i < word_res.size(); i++) begin
            r = word_res[i];
            r.last = (i == word_res.size() - 1);
            exp_q.insert(exp_q.size(), r);
        end
    endtask

    task automatic push_word(input logic [7:0] b, input logic e);
        text_word_t w;
        w.b = b;
        w.e = e;
        w.gap = gen_calm ? 0 : gap_len();
        w.drain = gen_drain;
        gen_drain = 1'b0;
        pend_q.insert(pend_q.size(), w);
        n_total++;
    endtask

    task automatic push_u(input logic [15:0] v);
        push_word(CH_BSLASH, 1'b0);
        push_word(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--) push_word(hex_char(v[i*4 +: 4]), 1'b0);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // driver
    text_word_t staged;
    bit         staged_ok = 1'b0;
    int         gap_cnt = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            text_byte <= 8'h00;
            text_end <= 1'b0;
            staged_ok = 1'b0;
            gap_cnt = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                decode_word(text_byte, text_end);
                n_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (!staged_ok && pend_q.size() > 0) begin
                    staged = pend_q.pop_front();
                    staged_ok = 1'b1;
                    gap_cnt = staged.gap;
                end
                if (staged_ok && gap_cnt == 0 && !(staged.drain && exp_q.size() > 0)) begin
                    in_valid <= 1'b1;
                    text_byte <= staged.b;
                    text_end <= staged.e;
                    staged_ok = 1'b0;
                end
                else begin
                    if (gap_cnt > 0) gap_cnt--;
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int stall_cnt = 0;

    always @(posedge clk or negedge rst_n)
    begin
        utf8_word_t want;
        int pick;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_cnt = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (exp_q.size() == 0) begin
                    report_mismatch("unexpected word", {status, out_byte}, 0);
                end
                else begin
                    want = exp_q.pop_front();
                    if (out_byte !== want.b) report_mismatch("out_byte", out_byte, want.b);
                    if (status !== want.st) report_mismatch("status", status, want.st);
                    if (run_last !== want.last) report_mismatch("run_last", run_last, want.last);
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
            end
            else begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    out_stall <= 1'b0;
                    stall_cnt = $urandom_range(0, 20);
                end
                else if (pick == 4) begin
                    out_stall <= 1'b0;
                    stall_cnt = $urandom_range(50, 150);
                end
                else begin
                    out_stall <= 1'b1;
                    stall_cnt = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                              : $urandom_range(7, 29);
                end
            end
        end
    end

    initial
    begin
        int         base;
        bit         drained;
        logic [7:0] c;
        logic [15:0] v;

        // directed
        push_word(8'hFF, 1'b1);
        push_word(CH_SPACE, 1'b0);
        push_word(CH_TAB, 1'b0);
        push_word(CH_CR, 1'b0);
        push_word(CH_LF, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(CH_QUOTE, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h01, 1'b0);
        push_u(16'hD83D);
        push_u(16'hDE00);
        push_word(CH_QUOTE, 1'b0);
        push_word(CH_QUOTE, 1'b0);
        push_word(CH_BSLASH, 1'b0);
        push_word(8'h00, 1'b1);

        // random strings
        base = n_total;
        drained = 1'b0;
        gen_drain = 1'b1;
        while (n_total < base + RandomWords) begin
            if (!drained && n_total > base + RandomWords / 2) begin
                gen_drain = 1'b1;
                drained = 1'b1;
            end
            gen_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) push_word(8'($urandom), $urandom_range(0, 3) == 0);
            end
            else begin
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 3))
                        0: push_word(CH_SPACE, 1'b0);
                        1: push_word(CH_TAB, 1'b0);
                        2: push_word(CH_CR, 1'b0);
                        default: push_word(CH_LF, 1'b0);
                    endcase
                end
                push_word(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 4))
                        0, 1:
                        begin
                            do c = 8'($urandom); while (c inside {CH_QUOTE, CH_BSLASH});
                            push_word(c, 1'b0);
                        end
                        2:
                        begin
                            case ($urandom_range(0, 7))
                                0: c = CH_QUOTE;
                                1: c = CH_BSLASH;
                                2: c = CH_SLASH;
                                3: c = CH_B;
                                4: c = CH_F;
                                5: c = CH_N;
                                6: c = CH_R;
                                default: c = CH_T;
                            endcase
                            push_word(CH_BSLASH, 1'b0);
                            push_word(c, 1'b0);
                        end
                        3:
                        begin
                            case ($urandom_range(0, 3))
                                0: v = 16'($urandom_range(0, 16'h7F));
                                1: v = 16'($urandom_range(16'h80, 16'h7FF));
                                2: v = 16'($urandom_range(16'h800, 16'hFFFF));
                                default: v = {6'b110111, 10'($urandom)};
                            endcase
                            if (v inside {[16'hD800:16'hDBFF]}) v = v ^ 16'h4000;
                            push_u(v);
                        end
                        default:
                        begin
                            push_u({6'b110110, 10'($urandom)});
                            push_u({6'b110111, 10'($urandom)});
                        end
                    endcase
                end
                case ($urandom_range(0, 15))
                    7: push_word(8'($urandom), 1'b1);
                    8:
                    begin
                        push_word(CH_BSLASH, 1'b0);
                        push_word(8'($urandom), 1'b1);
                    end
                    9, 10:
                    begin
                        push_word(CH_BSLASH, 1'b0);
                        push_word(CH_U, 1'b0);
                        repeat ($urandom_range(0, 3)) push_word(hex_char(4'($urandom)), 1'b0);
                        if ($urandom_range(0, 1)) begin
                            push_word(8'($urandom), 1'b1);
                        end
                        else begin
                            do c = 8'($urandom); while (hex_val(c) != NOT_HEX);
                            push_word(c, 1'b0);
                        end
                    end
                    11:
                    begin
                        do c = 8'($urandom);
                        while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N,
                                         CH_R, CH_T, CH_U});
                        push_word(CH_BSLASH, 1'b0);
                        push_word(c, 1'b0);
                    end
                    12:
                    begin
                        push_u({6'b110110, 10'($urandom)});
                        do c = 8'($urandom); while (c == CH_BSLASH);
                        push_word(c, $urandom_range(0, 2) == 0);
                    end
                    13:
                    begin
                        push_u({6'b110110, 10'($urandom)});
                        push_word(CH_BSLASH, 1'b0);
                        do c = 8'($urandom); while (c == CH_U);
                        push_word(c, $urandom_range(0, 2) == 0);
                    end
                    14:
                    begin
                        push_u({6'b110110, 10'($urandom)});
                        v = 16'($urandom);
                        if (v inside {[16'hDC00:16'hDFFF]}) v = v ^ 16'h4000;
                        push_u(v);
                    end
                    default: push_word(CH_QUOTE, 1'b0);
                endcase
            end
        end
        gen_calm = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (n_taken < n_total) @(posedge clk);
        while (exp_q.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #(TimeoutNs);
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/jsu_pkg.sv
src/jsu_scan.sv
src/jsu_emit.sv
src/json_string_unescape_utf8_top.sv
sim/tb.sv
